// ===== hdl/rlh_pkg.sv =====
`default_nettype none

package rlh_pkg;

  // fixed geometry of the histogram
  localparam int COORD_BITS  = 12;
  localparam int COUNT_BITS  = 25;
  localparam int SAMPLE_STEP = 24;
  localparam int BIN_BITS    = 8;
  localparam int NUM_BINS    = 1 << BIN_BITS;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // divisibility test by reciprocal multiplication: x is a multiple of the
  // step exactly when the fraction bits of x * GRID_MUL stay below GRID_MUL
  localparam int GRID_SHIFT    = COORD_BITS + 7;
  localparam int GRID_MUL_BITS = GRID_SHIFT + 1;
  localparam int PROD_BITS     = COORD_BITS + GRID_MUL_BITS;
  localparam logic [GRID_MUL_BITS-1:0] GRID_MUL =
    GRID_MUL_BITS'(((1 << GRID_SHIFT) + SAMPLE_STEP - 1) / SAMPLE_STEP);

  typedef struct packed {
    logic [1:0]            op;
    logic [COORD_BITS-1:0] x_pos;
    logic [COORD_BITS-1:0] y_pos;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [BIN_BITS-1:0]   bin_index;
  } rlh_in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] gray_count;
    logic [COUNT_BITS-1:0] red_count;
    logic [COUNT_BITS-1:0] green_count;
    logic [COUNT_BITS-1:0] blue_count;
  } rlh_out_t;

  // bin addresses presented to the four banks
  typedef struct packed {
    logic [BIN_BITS-1:0] gray;
    logic [BIN_BITS-1:0] red;
    logic [BIN_BITS-1:0] green;
    logic [BIN_BITS-1:0] blue;
  } rlh_addr_t;

  // what the transaction in the update stage does
  typedef struct packed {
    logic count;
    logic read;
  } rlh_stage_t;

  // clearing sweep write
  typedef struct packed {
    logic                we;
    logic [BIN_BITS-1:0] addr;
  } rlh_clr_t;

endpackage

`default_nettype wire

// ===== hdl/rgb_luma_histogram_top.sv =====
`default_nettype none

// rgb_luma_histogram_top: gray, red, green and blue histograms of 256 bins
//
// input channel: a transaction is taken at a clock edge with start high and
// busy low. in_data.op selects clear, pixel or read; op 3 does nothing.
// pixel and read transactions may follow each other in every cycle while
// busy is low: each bin is a read-modify-write in a registered-read memory,
// with the last write forwarded, so the memory read and write ports set the
// figure of one transaction per cycle.
// a clear holds busy high while one bin of every histogram is zeroed per
// cycle, until all 256 bins are swept; reset starts the same sweep.
// result channel: a read gives one result, out_valid high for exactly one
// cycle, raised from the update stage register through the result register;
// clear and pixel give none.
// the receiver cannot stall, so results are never held.
// configuration: cfg_full_resolution is written when cfg_valid and cfg_ready
// are high (cfg_ready is always high); the user must write it only while no
// transaction is in flight, unenforced by the block. it resets to 0, counting
// only pixels on the sampling grid. bins saturate at their largest count.

module rgb_luma_histogram_top (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire rlh_pkg::rlh_in_t in_data,
  output logic                  out_valid,
  output rlh_pkg::rlh_out_t     out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_full_resolution
);

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  state_t                       state_r;
  logic [rlh_pkg::BIN_BITS-1:0] sweep_r;
  logic                         full_res_r;
  logic                         out_valid_r;
  rlh_pkg::rlh_out_t            out_data_r;
  logic                         accept;
  rlh_pkg::rlh_addr_t           rd_addr;
  rlh_pkg::rlh_stage_t          stage;
  rlh_pkg::rlh_clr_t            clr;
  rlh_pkg::rlh_out_t            counts;

  assign busy      = (state_r == ST_CLEAR);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign clr.we    = (state_r == ST_CLEAR);
  assign clr.addr  = sweep_r;

  // decode and stage control
  rlh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .full_res (full_res_r),
    .rd_addr  (rd_addr),
    .stage    (stage)
  );

  // one bank per histogram
  rlh_bin_bank u_gray (
    .clk (clk), .rst_n (rst_n), .rd_addr (rd_addr.gray),
    .count_en (stage.count), .clr (clr), .count (counts.gray_count)
  );

  rlh_bin_bank u_red (
    .clk (clk), .rst_n (rst_n), .rd_addr (rd_addr.red),
    .count_en (stage.count), .clr (clr), .count (counts.red_count)
  );

  rlh_bin_bank u_green (
    .clk (clk), .rst_n (rst_n), .rd_addr (rd_addr.green),
    .count_en (stage.count), .clr (clr), .count (counts.green_count)
  );

  rlh_bin_bank u_blue (
    .clk (clk), .rst_n (rst_n), .rd_addr (rd_addr.blue),
    .count_en (stage.count), .clr (clr), .count (counts.blue_count)
  );

  // clearing sweep, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      full_res_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          sweep_r <= sweep_r + 1'b1;
          if (&sweep_r) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (accept && (in_data.op == rlh_pkg::OP_CLEAR)) begin
            state_r <= ST_CLEAR;
            sweep_r <= '0;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
          sweep_r <= '0;
        end
      endcase
      if (cfg_valid && cfg_ready) begin
        full_res_r <= cfg_full_resolution;
      end
      out_valid_r <= stage.read;
      if (stage.read) begin
        out_data_r <= counts;
      end
    end
  end

  // a result only follows a read in the update stage
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(stage.read))
    else $error("result without a read transaction");

  // a clear starts the sweep in the next cycle
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.op == rlh_pkg::OP_CLEAR)) |=> (busy && (sweep_r == '0)))
    else $error("clear did not start the sweep");

  // sweep writes and bin updates never share a cycle
  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(clr.we && stage.count))
    else $error("sweep and update write together");

  // read and count never both in the update stage
  a_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(stage.read && stage.count))
    else $error("update stage holds two operations");

endmodule

`default_nettype wire

// ===== hdl/rlh_front.sv =====
`default_nettype none

module rlh_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire rlh_pkg::rlh_in_t   in_data,
  input  wire logic               full_res,
  output rlh_pkg::rlh_addr_t      rd_addr,
  output rlh_pkg::rlh_stage_t     stage
);

  logic [12:0]                    gray_sum;
  logic [rlh_pkg::BIN_BITS-1:0]   gray;
  logic [rlh_pkg::PROD_BITS-1:0]  prod_x;
  logic [rlh_pkg::PROD_BITS-1:0]  prod_y;
  logic                           on_grid;
  logic                           is_read;
  rlh_pkg::rlh_stage_t            stage_r;

  // weighted luma, always below 256 after the shift
  assign gray_sum = 13'(in_data.red) * 13'd11 + {1'b0, in_data.green, 4'b0000}
                  + 13'(in_data.blue) * 13'd5;
  assign gray     = gray_sum[12:5];

  // sampling grid test on both coordinates
  assign prod_x  = rlh_pkg::PROD_BITS'(in_data.x_pos)
                 * rlh_pkg::PROD_BITS'(rlh_pkg::GRID_MUL);
  assign prod_y  = rlh_pkg::PROD_BITS'(in_data.y_pos)
                 * rlh_pkg::PROD_BITS'(rlh_pkg::GRID_MUL);
  assign on_grid = ({1'b0, prod_x[rlh_pkg::GRID_SHIFT-1:0]} < rlh_pkg::GRID_MUL)
                && ({1'b0, prod_y[rlh_pkg::GRID_SHIFT-1:0]} < rlh_pkg::GRID_MUL);

  // read addresses go to the memories at the accepting edge
  assign is_read       = (in_data.op == rlh_pkg::OP_READ);
  assign rd_addr.gray  = is_read ? in_data.bin_index : gray;
  assign rd_addr.red   = is_read ? in_data.bin_index : in_data.red;
  assign rd_addr.green = is_read ? in_data.bin_index : in_data.green;
  assign rd_addr.blue  = is_read ? in_data.bin_index : in_data.blue;

  // update stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r.count <= accept && (in_data.op == rlh_pkg::OP_PIXEL)
                    && (full_res || on_grid);
      stage_r.read  <= accept && is_read;
    end
  end

  assign stage = stage_r;

endmodule

`default_nettype wire

// ===== hdl/rlh_bin_bank.sv =====
`default_nettype none

module rlh_bin_bank (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [rlh_pkg::BIN_BITS-1:0]    rd_addr,
  input  wire logic                            count_en,
  input  wire rlh_pkg::rlh_clr_t               clr,
  output logic [rlh_pkg::COUNT_BITS-1:0]       count
);

  logic [rlh_pkg::COUNT_BITS-1:0] mem [rlh_pkg::NUM_BINS];
  logic [rlh_pkg::COUNT_BITS-1:0] rdata_r;
  logic [rlh_pkg::BIN_BITS-1:0]   addr_r;
  logic                           lw_vld_r;
  logic [rlh_pkg::BIN_BITS-1:0]   lw_addr_r;
  logic [rlh_pkg::COUNT_BITS-1:0] lw_data_r;
  logic [rlh_pkg::COUNT_BITS-1:0] cur;
  logic [rlh_pkg::COUNT_BITS-1:0] inc;

  // forward the write of the previous cycle, the memory read missed it
  assign cur   = (lw_vld_r && (lw_addr_r == addr_r)) ? lw_data_r : rdata_r;
  // saturating increment
  assign inc   = (&cur) ? cur : cur + 1'b1;
  assign count = cur;

  // bin memory, read every cycle, written by the sweep or an update
  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    addr_r  <= rd_addr;
    if (clr.we) begin
      mem[clr.addr] <= '0;
    end else if (count_en) begin
      mem[addr_r] <= inc;
    end
  end

  // last write record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_vld_r <= 1'b0;
    end else begin
      lw_vld_r <= clr.we || count_en;
    end
    lw_addr_r <= clr.we ? clr.addr : addr_r;
    lw_data_r <= clr.we ? '0 : inc;
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // op 3 is not decoded by the block and must leave everything untouched
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 325;
  localparam int GRID_POINTS =
    (((1 << rlh_pkg::COORD_BITS) - 1) / rlh_pkg::SAMPLE_STEP) + 1;

  typedef enum {ROW_ITEM, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    rlh_pkg::rlh_in_t   item;
    bit                 cfg_value;
    bit                 pinned;
    rlh_pkg::rlh_out_t  counts;
  } script_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  rlh_pkg::rlh_in_t  in_data;
  logic              out_valid;
  rlh_pkg::rlh_out_t out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_full_resolution;

  // histogram model held by the testbench
  bit [rlh_pkg::COUNT_BITS-1:0] gray_hist [rlh_pkg::NUM_BINS];
  bit [rlh_pkg::COUNT_BITS-1:0] red_hist [rlh_pkg::NUM_BINS];
  bit [rlh_pkg::COUNT_BITS-1:0] green_hist [rlh_pkg::NUM_BINS];
  bit [rlh_pkg::COUNT_BITS-1:0] blue_hist [rlh_pkg::NUM_BINS];
  bit                           count_all_pixels;

  rlh_pkg::rlh_out_t pending_reads [$];
  script_row_t       script [$];
  bit                pin_next;
  rlh_pkg::rlh_out_t pin_counts;
  bit                gaps_on;
  int                errors;
  int                cycles;
  rlh_pkg::rlh_in_t  last_pixel;

  rgb_luma_histogram_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_data            (out_data),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_full_resolution (cfg_full_resolution)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return (11 * r + 16 * g + 5 * b) >> 5;
  endfunction

  function automatic bit [rlh_pkg::COUNT_BITS-1:0] bumped(
      bit [rlh_pkg::COUNT_BITS-1:0] cnt);
    return (&cnt) ? cnt : cnt + 1'b1;
  endfunction

  function automatic void check_field(string name,
                                      logic [rlh_pkg::COUNT_BITS-1:0] want,
                                      logic [rlh_pkg::COUNT_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // compare results, then track configuration and accepted transactions
  always @(posedge clk) begin
    rlh_pkg::rlh_out_t want;
    int                luma;
    bit                on_grid;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_reads.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, out_data);
          errors++;
        end else begin
          want = pending_reads.pop_front();
          check_field("gray_count", want.gray_count, out_data.gray_count);
          check_field("red_count", want.red_count, out_data.red_count);
          check_field("green_count", want.green_count, out_data.green_count);
          check_field("blue_count", want.blue_count, out_data.blue_count);
        end
      end
      if (cfg_valid && cfg_ready)
        count_all_pixels = cfg_full_resolution;
      if (start && !busy) begin
        case (in_data.op)
          rlh_pkg::OP_CLEAR: begin
            for (int i = 0; i < rlh_pkg::NUM_BINS; i++) begin
              gray_hist[i]  = '0;
              red_hist[i]   = '0;
              green_hist[i] = '0;
              blue_hist[i]  = '0;
            end
          end
          rlh_pkg::OP_PIXEL: begin
            on_grid = (int'(in_data.x_pos) % rlh_pkg::SAMPLE_STEP == 0) &&
                      (int'(in_data.y_pos) % rlh_pkg::SAMPLE_STEP == 0);
            if (count_all_pixels || on_grid) begin
              luma = luma_of(in_data.red, in_data.green, in_data.blue);
              gray_hist[luma]           = bumped(gray_hist[luma]);
              red_hist[in_data.red]     = bumped(red_hist[in_data.red]);
              green_hist[in_data.green] = bumped(green_hist[in_data.green]);
              blue_hist[in_data.blue]   = bumped(blue_hist[in_data.blue]);
            end
          end
          rlh_pkg::OP_READ: begin
            want.gray_count  = gray_hist[in_data.bin_index];
            want.red_count   = red_hist[in_data.bin_index];
            want.green_count = green_hist[in_data.bin_index];
            want.blue_count  = blue_hist[in_data.bin_index];
            pending_reads.push_back(pin_next ? pin_counts : want);
          end
          default: ;
        endcase
      end
    end
  end

  // present one transaction, idling randomly first while gaps_on is set, until it is taken
  task automatic send(input rlh_pkg::rlh_in_t item, input bit pin,
                      input rlh_pkg::rlh_out_t counts);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 21) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    in_data    <= item;
    pin_next   = pin;
    pin_counts = counts;
    do @(posedge clk); while (busy);
  endtask

  // stop driving and wait until nothing is in flight
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_reads.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_full_resolution(input bit value);
    settle();
    @(negedge clk);
    cfg_valid           <= 1'b1;
    cfg_full_resolution <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(row_kind_t kind, logic [1:0] op, int x, int y,
                                  int r, int g, int b, int idx, bit cfg_value,
                                  bit pinned, int cg, int cr, int cgr, int cb);
    script_row_t row;
    row.kind               = kind;
    row.item.op            = op;
    row.item.x_pos         = rlh_pkg::COORD_BITS'(x);
    row.item.y_pos         = rlh_pkg::COORD_BITS'(y);
    row.item.red           = 8'(r);
    row.item.green         = 8'(g);
    row.item.blue          = 8'(b);
    row.item.bin_index     = rlh_pkg::BIN_BITS'(idx);
    row.cfg_value          = cfg_value;
    row.pinned             = pinned;
    row.counts.gray_count  = rlh_pkg::COUNT_BITS'(cg);
    row.counts.red_count   = rlh_pkg::COUNT_BITS'(cr);
    row.counts.green_count = rlh_pkg::COUNT_BITS'(cgr);
    row.counts.blue_count  = rlh_pkg::COUNT_BITS'(cb);
    script.push_back(row);
  endfunction

  // random transaction, mostly pixels on the grid or from a small palette so
  // that reads land on bins that hold counts
  function automatic rlh_pkg::rlh_in_t random_item();
    rlh_pkg::rlh_in_t it;
    logic [63:0]      raw;
    int               sel;
    raw = {$urandom, $urandom};
    it  = raw[$bits(rlh_pkg::rlh_in_t)-1:0];
    sel = $urandom_range(99);
    if (sel < 2)
      it.op = rlh_pkg::OP_CLEAR;
    else if (sel < 5)
      it.op = OP_NONE;
    else if (sel < 37)
      it.op = rlh_pkg::OP_READ;
    else
      it.op = rlh_pkg::OP_PIXEL;
    if (it.op == rlh_pkg::OP_PIXEL) begin
      if ($urandom_range(1) == 1) begin
        it.x_pos = rlh_pkg::COORD_BITS'(rlh_pkg::SAMPLE_STEP
                                        * $urandom_range(GRID_POINTS - 1));
        it.y_pos = rlh_pkg::COORD_BITS'(rlh_pkg::SAMPLE_STEP
                                        * $urandom_range(GRID_POINTS - 1));
      end
      if ($urandom_range(2) == 0) begin
        it.red   = 8'(85 * $urandom_range(3));
        it.green = 8'(85 * $urandom_range(3));
        it.blue  = 8'(85 * $urandom_range(3));
      end
      last_pixel = it;
    end else if (it.op == rlh_pkg::OP_READ) begin
      case ($urandom_range(4))
        0: it.bin_index = last_pixel.red;
        1: it.bin_index = last_pixel.green;
        2: it.bin_index = last_pixel.blue;
        3: it.bin_index = rlh_pkg::BIN_BITS'(luma_of(last_pixel.red, last_pixel.green,
                                                     last_pixel.blue));
        default: ;
      endcase
    end
    return it;
  endfunction

  initial begin
    rlh_pkg::rlh_out_t none;
    rlh_pkg::rlh_in_t  item;
    int                taken;
    none                = '0;
    rst_n               = 1'b0;
    start               = 1'b0;
    in_data             = '0;
    cfg_valid           = 1'b0;
    cfg_full_resolution = 1'b0;
    count_all_pixels    = 1'b0;
    pin_next            = 1'b0;
    pin_counts          = '0;
    gaps_on             = 1'b1;
    errors              = 0;
    cycles              = 0;
    last_pixel          = '0;

    // directed table: kind op x y r g b bin cfg pinned gray red green blue
    // reads straight after reset see empty bins
    add_row(ROW_ITEM, rlh_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_READ, 0, 0, 0, 0, 0, 255, 0, 1, 0, 0, 0, 0);
    // white and black at the grid origin
    add_row(ROW_ITEM, rlh_pkg::OP_PIXEL, 0, 0, 255, 255, 255, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_READ, 0, 0, 0, 0, 0, 255, 0, 1, 1, 1, 1, 1);
    add_row(ROW_ITEM, rlh_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 1);
    // last grid row, then points just off the grid
    add_row(ROW_ITEM, rlh_pkg::OP_PIXEL, 24, 4080, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_PIXEL, 4095, 0, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_PIXEL, 23, 24, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_READ, 0, 0, 0, 0, 0, 255, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_READ, 0, 0, 0, 0, 0, 87, 0, 0, 0, 0, 0, 0);
    // unused op with every field set
    add_row(ROW_ITEM, OP_NONE, 4095, 4095, 255, 255, 255, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // clear empties every bin
    add_row(ROW_ITEM, rlh_pkg::OP_CLEAR, 4095, 4095, 255, 255, 255, 255, 0, 0,
            0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_READ, 0, 0, 0, 0, 0, 255, 0, 1, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_PIXEL, 48, 48, 0, 255, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_READ, 0, 0, 0, 0, 0, 127, 0, 0, 0, 0, 0, 0);
    // full resolution counts off-grid pixels
    add_row(ROW_CONFIG, OP_NONE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_PIXEL, 4095, 4095, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_PIXEL, 4095, 4095, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, rlh_pkg::OP_READ, 0, 0, 0, 0, 0, 2, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CONFIG, OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    // reset
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed part
    foreach (script[i]) begin
      if (script[i].kind == ROW_CONFIG)
        write_full_resolution(script[i].cfg_value);
      else
        send(script[i].item, script[i].pinned, script[i].counts);
    end

    // random phases, alternating the register, one phase without gaps
    for (int phase = 0; phase < PHASES; phase++) begin
      write_full_resolution(phase % 2 == 0);
      gaps_on = (phase != 2);
      taken   = 0;
      while (taken < ITEMS_PER_PHASE) begin
        item = random_item();
        send(item, 1'b0, none);
        if (item.op != OP_NONE)
          taken++;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
